// ===== rtl/fbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// fbrf_pkg
// Shared codes and constants of the frame store rectangle fill block.
// ----------------------------------------------------------------------------
package fbrf_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_FILL  = 2'd0;
    localparam kind_t KIND_CLEAR = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;

    localparam int BYTES_PER_COLOR_PIXEL = 3;

    // gray = (r + g + b) * 683 >> 11, exact floor of sum / 3 for sums up to 765
    localparam int GRAY_MUL   = 683;
    localparam int GRAY_SHIFT = 11;

    // longest row run in bytes: 3 * 127
    localparam int LEN_W = 9;

    localparam int SUM_W  = 10;
    localparam int PROD_W = 20;

endpackage

// ===== rtl/fbrf_ram.sv =====
// ----------------------------------------------------------------------------
// fbrf_ram
// Byte-wide frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbrf_ram #(
    parameter int DEPTH = 6144,
    parameter int AW    = 13
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/framebuffer_rect_fill.sv =====
// ----------------------------------------------------------------------------
// framebuffer_rect_fill
// Byte frame store for an LED matrix with rectangle fill, clear and byte read.
// ----------------------------------------------------------------------------
// read: result strobe in the cycle after the accepting edge, 1 cycle busy
// fill: setup states SETUP and SETUP2, then one byte written per cycle (1 per pixel in gray
//   mode, 3 in color mode), all through the single store write port
// clear: one store byte per cycle (3*DISPLAY_WIDTH*DISPLAY_HEIGHT, 6144 default)
// after reset the same clearing pass runs with busy high; results cannot stall
// ----------------------------------------------------------------------------
module framebuffer_rect_fill #(
    parameter int DISPLAY_WIDTH  = 64,
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fbrf_pkg::kind_t kind,
    input  logic [6:0]    left_x,
    input  logic [5:0]    top_y,
    input  logic [6:0]    right_x,
    input  logic [5:0]    bottom_y,
    input  logic [23:0]   color,
    input  logic [12:0]   read_address,
    output logic          result_valid,
    output logic [7:0]    read_data,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);

    import fbrf_pkg::*;

    localparam int STORE_BYTES = BYTES_PER_COLOR_PIXEL * DISPLAY_WIDTH * DISPLAY_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_SETUP2 = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic             gray_mode_reg;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    row_addr_reg, row_addr_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       phase_reg, phase_next;
    logic [5:0]       y_reg, y_next;
    logic [5:0]       ye_reg, ye_next;
    logic [6:0]       x0_reg, x0_next;
    logic [23:0]      color_reg, color_next;
    logic [7:0]       gray_reg, gray_next;
    logic             rd_ok_reg, rd_ok_next;

    logic             accept;
    logic [6:0]       xe_calc;
    logic [5:0]       ye_calc;
    logic [6:0]       run_px;
    logic             fill_empty;
    logic [SUM_W-1:0] gray_sum;
    logic [PROD_W-1:0] gray_prod;
    logic [AW-1:0]    stride;
    logic             rd_in_range;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;

    fbrf_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // per-axis clipping to the display
    assign xe_calc = (32'(right_x) < DISPLAY_WIDTH) ? right_x : 7'(DISPLAY_WIDTH);
    assign ye_calc = (32'(bottom_y) < DISPLAY_HEIGHT) ? bottom_y : 6'(DISPLAY_HEIGHT);
    assign fill_empty = (left_x >= xe_calc) || (top_y >= ye_calc);
    assign run_px  = xe_calc - left_x;

    assign gray_sum  = SUM_W'(color[23:16]) + SUM_W'(color[15:8]) + SUM_W'(color[7:0]);
    assign gray_prod = PROD_W'(gray_sum) * PROD_W'(GRAY_MUL);

    assign stride = gray_mode_reg ? AW'(DISPLAY_WIDTH)
                                  : AW'(BYTES_PER_COLOR_PIXEL * DISPLAY_WIDTH);

    assign rd_in_range = (32'(read_address) < STORE_BYTES);
    assign rd_en       = accept && (kind == KIND_READ) && rd_in_range;
    assign rd_addr     = AW'(read_address);

    assign wr_en   = (state_reg == ST_FILL) || (state_reg == ST_CLEAR);
    assign wr_addr = addr_reg;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_data = 8'd0;
        end
        else if (gray_mode_reg)
        begin
            wr_data = gray_reg;
        end
        else
        begin
            unique case (phase_reg)
                2'd0:    wr_data = color_reg[23:16];
                2'd1:    wr_data = color_reg[15:8];
                default: wr_data = color_reg[7:0];
            endcase
        end
    end

    assign result_valid = (state_reg == ST_READ);
    assign read_data    = rd_ok_reg ? rd_data : 8'd0;

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        row_addr_next = row_addr_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        phase_next    = phase_reg;
        y_next        = y_reg;
        ye_next       = ye_reg;
        x0_next       = x0_reg;
        color_next    = color_reg;
        gray_next     = gray_reg;
        rd_ok_next    = rd_ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (kind == KIND_FILL)
                    begin
                        if (!fill_empty)
                        begin
                            state_next = ST_SETUP;
                            x0_next    = left_x;
                            y_next     = top_y;
                            ye_next    = ye_calc;
                            color_next = color;
                            gray_next  = gray_prod[GRAY_SHIFT +: 8];
                            len_next   = gray_mode_reg ? LEN_W'(run_px)
                                       : LEN_W'(run_px) + LEN_W'({run_px, 1'b0});
                        end
                    end
                    else if (kind == KIND_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                        addr_next  = '0;
                    end
                    else if (kind == KIND_READ)
                    begin
                        state_next = ST_READ;
                        rd_ok_next = rd_in_range;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SETUP:
            begin
                // pixel index of the first pixel
                addr_next  = AW'(32'(y_reg) * DISPLAY_WIDTH + 32'(x0_reg));
                state_next = ST_SETUP2;
            end
            ST_SETUP2:
            begin
                if (!gray_mode_reg)
                begin
                    addr_next = AW'({addr_reg, 1'b0}) + addr_reg;
                end
                row_addr_next = gray_mode_reg ? addr_reg : AW'({addr_reg, 1'b0}) + addr_reg;
                cnt_next      = '0;
                phase_next    = 2'd0;
                state_next    = ST_FILL;
            end
            ST_FILL:
            begin
                if (cnt_reg == len_reg - LEN_W'(1))
                begin
                    if (y_reg + 6'd1 == ye_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    y_next        = y_reg + 6'd1;
                    row_addr_next = row_addr_reg + stride;
                    addr_next     = row_addr_reg + stride;
                    cnt_next      = '0;
                    phase_next    = 2'd0;
                end
                else
                begin
                    addr_next  = addr_reg + AW'(1);
                    cnt_next   = cnt_reg + LEN_W'(1);
                    phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                end
            end
            ST_CLEAR:
            begin
                if (addr_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            gray_mode_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            rd_ok_reg <= rd_ok_next;
            if (cfg_wr_en)
            begin
                gray_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_addr_reg <= row_addr_next;
        cnt_reg      <= cnt_next;
        len_reg      <= len_next;
        phase_reg    <= phase_next;
        y_reg        <= y_next;
        ye_reg       <= ye_next;
        x0_reg       <= x0_next;
        color_reg    <= color_next;
        gray_reg     <= gray_next;
    end

    // a result only follows a read transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && (kind == KIND_READ)))
        else $error("result without a read transfer");

    // every store write stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < STORE_BYTES))
        else $error("store write out of range");

    // the byte counter never runs past the row length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (cnt_reg < len_reg))
        else $error("row counter overran row length");

    // a fill never walks past the clipped bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (y_reg < ye_reg))
        else $error("fill row beyond clipped bottom");

    // every store read is followed by a result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> result_valid)
        else $error("store read without result");

endmodule
